### sv/fpea_pkg.sv
package fpea_pkg;

    localparam int DEF_MAX_FREE_EXTENTS = 16;
    localparam int DEF_MAX_LIVE_BLOCKS  = 16;
    localparam int DEF_OFFSET_BITS      = 20;

    localparam int SIZE_BITS   = 21;
    localparam int REGION_BITS = 21;
    localparam int STATUS_BITS = 3;
    localparam int FIELD_BITS  = 20;

    localparam logic [SIZE_BITS-1:0]   HDR_BYTES    = 21'd16;
    localparam logic [REGION_BITS-1:0] REGION_RESET = 21'd12288;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_SIZE = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_SPACE = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_LIVE = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd4;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;
    localparam logic [1:0] FIT_BEST  = 2'd0;
    localparam logic [1:0] FIT_WORST = 2'd1;
    localparam logic [1:0] FIT_FIRST = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;        // reload the tables from the written region value
        logic load;        // capture a request
        logic scan_clr;    // restart the scan index
        logic scan_step;   // evaluate one table entry, advance index
        logic alloc_commit;
        logic free_commit;
        logic shift_step;  // move one free entry during insert or remove
        logic finish;      // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic bad_size;
        logic bad_style;
        logic scan_last;   // current index is the final one of the scan
        logic found;
        logic slot_ok;
        logic hit;
        logic need_drop;   // alloc or merge removes an extent
        logic need_put;    // free inserts a new extent
        logic free_full;
        logic shift_done;
    } t_sts;

endpackage

### sv/fit_policy_extent_allocator_unit.sv
// Channel   | Handshake                    | Payload
// s_axis    | s_axis_tvalid/s_axis_tready  | tdata: command, request_size, fit_style,
//           |                              |        block_address
// m_axis    | m_axis_tvalid/m_axis_tready  | tdata: status, granted_address,
//           |                              |        granted_size
// config    | i_cfg_we                     | i_cfg_data: region_bytes
//
// Each beat passes a check, a scan of the 16-entry free and live tables (one entry a
// cycle), a decision and a result; no new beat is taken until the block is idle again.
// Removing or inserting a free extent adds a shift that moves one entry a cycle; an
// alloc with a zero size or unknown style skips the scan and the decision.
// Reset is synchronous and active low; it restores a 12288-byte region.
// A finished result waits in the output register while the next request is
// taken; the controller only stalls when that register is still full.
module fit_policy_extent_allocator_unit
    import fpea_pkg::*;
#(
    parameter int MAX_FREE_EXTENTS = DEF_MAX_FREE_EXTENTS,
    parameter int MAX_LIVE_BLOCKS  = DEF_MAX_LIVE_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [20:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[0], request_size[21:1], fit_style[23:22], block_address[43:24]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], granted_address[22:3], granted_size[43:23]
    output logic [47:0] m_axis_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;
    logic r_ovalid;
    logic w_in_fire;
    logic [STATUS_BITS-1:0] w_status;
    logic [FIELD_BITS-1:0]  w_gaddr;
    logic [SIZE_BITS-1:0]   w_gsize;

    // A new request is taken while the previous result still waits.
    assign s_axis_tready = !w_busy && !i_cfg_we;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    fpea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_fire  (w_in_fire),
        .i_out_free (!r_ovalid || m_axis_tready),
        .i_sts      (w_sts),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd)
    );

    fpea_dp #(
        .MAX_FREE_EXTENTS (MAX_FREE_EXTENTS),
        .MAX_LIVE_BLOCKS  (MAX_LIVE_BLOCKS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (w_cmd),
        .i_command         (s_axis_tdata[0]),
        .i_request_size    (s_axis_tdata[21:1]),
        .i_fit_style       (s_axis_tdata[23:22]),
        .i_block_address   (s_axis_tdata[43:24]),
        .o_sts             (w_sts),
        .o_status          (w_status),
        .o_granted_address (w_gaddr),
        .o_granted_size    (w_gsize)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, w_gsize, w_gaddr, w_status};

endmodule

### sv/fpea_ctrl.sv
module fpea_ctrl
    import fpea_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_in_fire,
    input  logic i_out_free,
    input  t_sts i_sts,
    output logic o_busy,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        o_cmd.init = i_cfg_we;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.is_free && (i_sts.bad_size || i_sts.bad_style)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.scan_clr = 1'b1;
                if (!i_sts.is_free) begin
                    if (i_sts.found && i_sts.slot_ok) begin
                        o_cmd.alloc_commit = 1'b1;
                        n_state = i_sts.need_drop ? S_SHIFT : S_DONE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    if (i_sts.hit && !i_sts.free_full) begin
                        o_cmd.free_commit = 1'b1;
                        n_state = (i_sts.need_drop || i_sts.need_put) ? S_SHIFT : S_DONE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/fpea_dp.sv
module fpea_dp
    import fpea_pkg::*;
#(
    parameter int MAX_FREE_EXTENTS = DEF_MAX_FREE_EXTENTS,
    parameter int MAX_LIVE_BLOCKS  = DEF_MAX_LIVE_BLOCKS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [REGION_BITS-1:0] i_cfg_data,
    input  t_cmd                   i_cmd,
    input  logic                   i_command,
    input  logic [SIZE_BITS-1:0]   i_request_size,
    input  logic [1:0]             i_fit_style,
    input  logic [FIELD_BITS-1:0]  i_block_address,
    output t_sts                   o_sts,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [FIELD_BITS-1:0]  o_granted_address,
    output logic [SIZE_BITS-1:0]   o_granted_size
);

    localparam int FI  = (MAX_FREE_EXTENTS > 1) ? $clog2(MAX_FREE_EXTENTS) : 1;
    localparam int LI  = (MAX_LIVE_BLOCKS > 1) ? $clog2(MAX_LIVE_BLOCKS) : 1;
    localparam int FC  = $clog2(MAX_FREE_EXTENTS + 1);
    localparam int SI  = (FC > LI + 1) ? FC : LI + 1;
    localparam int OB  = DEF_OFFSET_BITS;
    localparam int AW  = OB + 2;  // room for offset plus header plus size sums
    localparam int SW  = (SIZE_BITS > OB + 1) ? SIZE_BITS : OB + 1;

    // Clamped form of the region value being written.
    logic [AW-1:0]          w_reg_v;
    logic [AW-1:0]          w_top;

    logic [OB-1:0] r_foff [MAX_FREE_EXTENTS];
    logic [SW-1:0] r_fsz  [MAX_FREE_EXTENTS];
    logic [FC-1:0] r_fcnt;
    logic [OB-1:0] r_loff [MAX_LIVE_BLOCKS];
    logic [SW-1:0] r_lsz  [MAX_LIVE_BLOCKS];
    logic [MAX_LIVE_BLOCKS-1:0] r_lval;

    logic                  r_cmd;
    logic [1:0]            r_style;
    logic [SW:0]           r_need;
    logic [OB-1:0]         r_uaddr;
    logic [SI-1:0]         r_idx;
    logic                  r_found;
    logic [FI-1:0]         r_pick;
    logic [SW-1:0]         r_psz;
    logic                  r_stop;      // first-fit hit seen
    logic                  r_hit;
    logic [LI-1:0]         r_lslot;
    logic                  r_have_slot;
    logic [LI-1:0]         r_slot;
    logic [OB-1:0]         r_boff;
    logic [SW-1:0]         r_bsz;
    logic                  r_drop;      // shift left from r_sh, else right
    logic [FC-1:0]         r_sh;
    logic [FC-1:0]         r_sh_end;
    logic [STATUS_BITS-1:0] r_status;
    logic [FIELD_BITS-1:0] r_gaddr;
    logic [SIZE_BITS-1:0]  r_gsize;
    logic [STATUS_BITS-1:0] r_res_st;
    logic [FIELD_BITS-1:0] r_res_addr;
    logic [SIZE_BITS-1:0]  r_res_size;

    logic [SW:0]   w_need_in;
    logic [FI-1:0] w_fi;
    logic [LI-1:0] w_li;
    logic          w_fin;
    logic          w_lin;
    logic [SW-1:0] w_s;
    logic          w_fits;
    logic [SI-1:0] w_scan_end;
    logic [AW-1:0] w_bend;
    logic [AW-1:0] w_pend;
    logic [AW-1:0] w_rest;
    logic          w_mnext;
    logic          w_mprev;
    logic [FC-1:0] w_pos_c;
    logic [FI-1:0] w_pos;
    logic [FI-1:0] w_posm1;

    always_comb begin
        w_reg_v = AW'(i_cfg_data) & ~AW'(7);
        w_top   = AW'(1) << OB;
        if (w_reg_v > w_top) w_reg_v = w_top;
        if (w_reg_v < AW'(32)) w_reg_v = AW'(32);
    end

    assign w_need_in = ((SW+1)'(i_request_size) + (SW+1)'(7)) & ~(SW+1)'(7);
    assign w_fi  = r_idx[FI-1:0];
    assign w_li  = r_idx[LI-1:0];
    assign w_fin = (r_idx < SI'(r_fcnt));
    assign w_lin = (r_idx < SI'(MAX_LIVE_BLOCKS));
    assign w_s   = r_fsz[w_fi];
    assign w_fits = ({1'b0, w_s} >= r_need);
    assign w_scan_end = (SI'(MAX_FREE_EXTENTS) > SI'(MAX_LIVE_BLOCKS)) ?
                        SI'(MAX_FREE_EXTENTS) : SI'(MAX_LIVE_BLOCKS);

    // Insert position for a free: the first extent above the hit block's header,
    // found by a priority pass over the address-ordered free table.
    always_comb begin
        w_pos_c = r_fcnt;
        for (int k = MAX_FREE_EXTENTS - 1; k >= 0; k--) begin
            if (FC'(k) < r_fcnt && r_foff[k] > r_loff[r_slot]) w_pos_c = FC'(k);
        end
    end

    assign w_pos   = w_pos_c[FI-1:0];
    assign w_posm1 = FI'(w_pos_c - FC'(1));
    assign w_bend  = AW'(r_loff[r_slot]) + AW'(HDR_BYTES) + AW'(r_lsz[r_slot]);
    assign w_pend  = AW'(r_foff[w_posm1]) + AW'(HDR_BYTES) + AW'(r_fsz[w_posm1]);
    assign w_mnext = (w_pos_c < r_fcnt) && (w_bend == AW'(r_foff[w_pos]));
    assign w_mprev = (w_pos_c != '0) && (w_pend == AW'(r_loff[r_slot]));
    assign w_rest  = AW'(r_psz) - AW'(r_need);

    always_comb begin
        o_sts            = '0;
        o_sts.is_free    = r_cmd;
        o_sts.bad_size   = (r_need == '0);
        o_sts.bad_style  = (r_style == 2'd3);
        o_sts.scan_last  = (r_idx == w_scan_end - SI'(1));
        o_sts.found      = r_found;
        o_sts.slot_ok    = r_have_slot;
        o_sts.hit        = r_hit;
        o_sts.free_full  = !w_mprev && !w_mnext && (r_fcnt >= FC'(MAX_FREE_EXTENTS));
        if (r_cmd) begin
            o_sts.need_drop = w_mprev && w_mnext;
            o_sts.need_put  = !w_mprev && !w_mnext;
        end else begin
            o_sts.need_drop = (w_rest < AW'(HDR_BYTES));
        end
        o_sts.shift_done = (r_sh == r_sh_end);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_style <= i_fit_style;
            r_need  <= w_need_in;
            r_uaddr <= OB'(i_block_address);
        end
        if (i_cmd.scan_clr) begin
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_stop      <= 1'b0;
            r_hit       <= 1'b0;
            r_have_slot <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + SI'(1);
            // Free-table side: fit search.
            if (w_fin && !r_stop) begin
                if (!r_cmd) begin
                    if (w_fits && (!r_found ||
                        (r_style == FIT_BEST && w_s < r_psz) ||
                        (r_style == FIT_WORST && w_s > r_psz))) begin
                        r_found <= 1'b1;
                        r_pick  <= w_fi;
                        r_psz   <= w_s;
                    end
                    if (w_fits && r_style == FIT_FIRST) r_stop <= 1'b1;
                end
            end
            // Live-table side: free slot or address match.
            if (w_lin) begin
                if (!r_have_slot && !r_lval[w_li]) begin
                    r_have_slot <= 1'b1;
                    r_lslot     <= w_li;
                end
                if (!r_hit && r_lval[w_li] &&
                    (AW'(r_loff[w_li]) + AW'(HDR_BYTES) == AW'(r_uaddr))) begin
                    r_hit  <= 1'b1;
                    r_slot <= w_li;
                end
            end
        end
        if (i_cmd.finish) begin
            r_res_st   <= r_status;
            r_res_addr <= r_gaddr;
            r_res_size <= r_gsize;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt   <= FC'(1);
            r_lval   <= '0;
            r_status <= ST_OK;
            r_gaddr  <= '0;
            r_gsize  <= '0;
            r_sh     <= '0;
            r_sh_end <= '0;
            r_drop   <= 1'b0;
            for (int k = 0; k < MAX_FREE_EXTENTS; k++) begin
                r_foff[k] <= '0;
                r_fsz[k]  <= (k == 0) ? SW'(REGION_RESET - HDR_BYTES) : '0;
            end
        end else if (i_cmd.init) begin
            r_fcnt   <= FC'(1);
            r_lval   <= '0;
            for (int k = 0; k < MAX_FREE_EXTENTS; k++) begin
                r_foff[k] <= '0;
                r_fsz[k]  <= (k == 0) ? SW'(w_reg_v - AW'(HDR_BYTES)) : '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_status <= ST_OK;
                r_gaddr  <= '0;
                r_gsize  <= '0;
                if (i_command == CMD_ALLOC && w_need_in == '0) begin
                    r_status <= ST_BAD_SIZE;
                end else if (i_command == CMD_ALLOC && i_fit_style == 2'd3) begin
                    r_status <= ST_NO_SPACE;
                end
            end
            if (i_cmd.scan_clr && !i_cmd.load) begin
                // End of scan: report failures.
                if (!r_cmd) begin
                    if (!r_found) r_status <= ST_NO_SPACE;
                    else if (!r_have_slot) r_status <= ST_FULL;
                end else begin
                    if (!r_hit) r_status <= ST_NOT_LIVE;
                    else if (o_sts.free_full) r_status <= ST_FULL;
                end
            end
            if (i_cmd.alloc_commit) begin
                r_lval[r_lslot] <= 1'b1;
                r_loff[r_lslot] <= r_foff[r_pick];
                r_gaddr <= FIELD_BITS'(AW'(r_foff[r_pick]) + AW'(HDR_BYTES));
                if (w_rest < AW'(HDR_BYTES)) begin
                    r_lsz[r_lslot] <= r_psz;
                    r_gsize  <= SIZE_BITS'(r_psz);
                    r_drop   <= 1'b1;
                    r_sh     <= FC'(r_pick);
                    r_sh_end <= r_fcnt - FC'(1);
                end else begin
                    r_lsz[r_lslot] <= SW'(r_need);
                    r_gsize <= SIZE_BITS'(r_need);
                    r_foff[r_pick] <= OB'(AW'(r_foff[r_pick]) + AW'(HDR_BYTES) + AW'(r_need));
                    r_fsz[r_pick]  <= SW'(w_rest - AW'(HDR_BYTES));
                end
            end
            if (i_cmd.free_commit) begin
                r_lval[r_slot] <= 1'b0;
                r_boff <= r_loff[r_slot];
                r_bsz  <= r_lsz[r_slot];
                if (w_mprev && w_mnext) begin
                    r_fsz[w_posm1] <= SW'(AW'(r_fsz[w_posm1]) + AW'(HDR_BYTES) +
                        AW'(r_lsz[r_slot]) + AW'(HDR_BYTES) + AW'(r_fsz[w_pos]));
                    r_drop   <= 1'b1;
                    r_sh     <= w_pos_c;
                    r_sh_end <= r_fcnt - FC'(1);
                end else if (w_mprev) begin
                    r_fsz[w_posm1] <= SW'(AW'(r_fsz[w_posm1]) + AW'(HDR_BYTES) +
                        AW'(r_lsz[r_slot]));
                end else if (w_mnext) begin
                    r_foff[w_pos] <= r_loff[r_slot];
                    r_fsz[w_pos]  <= SW'(AW'(r_fsz[w_pos]) + AW'(HDR_BYTES) +
                        AW'(r_lsz[r_slot]));
                end else begin
                    r_drop   <= 1'b0;
                    r_sh     <= r_fcnt;
                    r_sh_end <= w_pos_c;
                end
            end
            if (i_cmd.shift_step) begin
                if (r_drop) begin
                    if (r_sh == r_sh_end) begin
                        r_foff[r_sh[FI-1:0]] <= '0;
                        r_fsz[r_sh[FI-1:0]]  <= '0;
                        r_fcnt <= r_fcnt - FC'(1);
                    end else begin
                        r_foff[r_sh[FI-1:0]] <= r_foff[FI'(r_sh + FC'(1))];
                        r_fsz[r_sh[FI-1:0]]  <= r_fsz[FI'(r_sh + FC'(1))];
                        r_sh <= r_sh + FC'(1);
                    end
                end else begin
                    if (r_sh == r_sh_end) begin
                        r_foff[r_sh[FI-1:0]] <= r_boff;
                        r_fsz[r_sh[FI-1:0]]  <= r_bsz;
                        r_fcnt <= r_fcnt + FC'(1);
                    end else begin
                        r_foff[r_sh[FI-1:0]] <= r_foff[FI'(r_sh - FC'(1))];
                        r_fsz[r_sh[FI-1:0]]  <= r_fsz[FI'(r_sh - FC'(1))];
                        r_sh <= r_sh - FC'(1);
                    end
                end
            end
        end
    end

    assign o_status          = r_res_st;
    assign o_granted_address = r_res_addr;
    assign o_granted_size    = r_res_size;

endmodule
